// ===== hw/rtl/ccw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccw_pkg
// Shared types and widths for the coin change way counter.
// ----------------------------------------------------------------------------
package ccw_pkg;

  localparam int unsigned TARGET_W = 10;
  localparam int unsigned COIN_W   = 16;
  localparam int unsigned COUNT_W  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PASS,
    ST_FLUSH,
    ST_READ_TOP,
    ST_EMIT
  } ccw_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/coin_change_way_counter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coin_change_way_counter_unit
// Counts coin combinations for a target amount with a table walk per coin.
// ----------------------------------------------------------------------------
// One coin is taken per input transaction and the unit stays stalled while it
// works on it. A coin marked first costs a restart sweep of the table up to the
// target. A coin between 1 and the target then walks the table from the coin
// value up to the target through one shared 32-bit adder, one entry per cycle;
// other coins skip the walk. A coin marked last then reads the count at the
// target into the output register. The time for one coin is set by the single
// write port of the table RAM, and a still-held output register can keep the
// unit waiting to emit. A finished count may wait in the output register while
// the next coin is already being processed.
module coin_change_way_counter_unit #(
  parameter int unsigned MAX_AMOUNT = 1023
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ccw_pkg::TARGET_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ccw_pkg::COIN_W-1:0]    coin_value,
  input  wire logic                          first_coin,
  input  wire logic                          last_coin,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ccw_pkg::COUNT_W-1:0]   way_count
);

  import ccw_pkg::*;

  localparam int unsigned DEPTH = MAX_AMOUNT + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  ccw_state_t state, state_next;

  logic [TARGET_W-1:0] target_amount;
  logic [AW-1:0]       top_q;
  logic [AW-1:0]       coin_q;
  logic                coin_ok_q;
  logic                last_q;
  logic [AW-1:0]       cnt, cnt_next;

  logic                s1_valid;
  logic [AW-1:0]       s1_addr;
  logic                fwd_hit;
  logic [COUNT_W-1:0]  fwd_data;

  logic [16:0]         tgt_ext;
  logic [16:0]         tgt_sat;
  logic [AW-1:0]       top_cfg;
  logic                coin_ok_in;
  logic                accept;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [COUNT_W-1:0]  wr_data;
  logic [AW-1:0]       rd_addr_a;
  logic [AW-1:0]       rd_addr_b;
  logic [COUNT_W-1:0]  rd_data_a;
  logic [COUNT_W-1:0]  rd_data_b;
  logic [COUNT_W-1:0]  lower_val;
  logic [COUNT_W-1:0]  sum;
  logic                out_free;

  assign cfg_ready = 1'b1;

  // Targets beyond the table are clamped to its last entry.
  assign tgt_ext    = 17'(target_amount);
  assign tgt_sat    = (tgt_ext > 17'(MAX_AMOUNT)) ? 17'(MAX_AMOUNT) : tgt_ext;
  assign top_cfg    = tgt_sat[AW-1:0];
  assign coin_ok_in = (coin_value != '0) && (17'(coin_value) <= 17'(top_cfg));
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;

  // With a coin of one the lower entry is the one being written this cycle,
  // so its new value is forwarded around the RAM.
  assign lower_val = fwd_hit ? fwd_data : rd_data_b;
  assign sum       = rd_data_a + lower_val;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (first_coin) begin
            state_next = ST_CLEAR;
          end else if (coin_ok_in) begin
            state_next = ST_PASS;
          end else if (last_coin) begin
            state_next = ST_READ_TOP;
          end
        end
      end
      ST_CLEAR: begin
        if (cnt == top_q) begin
          if (coin_ok_q) begin
            state_next = ST_PASS;
          end else if (last_q) begin
            state_next = ST_READ_TOP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PASS: begin
        if (cnt == top_q) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = last_q ? ST_READ_TOP : ST_IDLE;
      end
      ST_READ_TOP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_next = first_coin ? '0 : coin_value[AW-1:0];
        end
      end
      ST_CLEAR: begin
        cnt_next = (cnt == top_q) ? coin_q : cnt + AW'(1);
      end
      ST_PASS: begin
        if (cnt != top_q) begin
          cnt_next = cnt + AW'(1);
        end
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    rd_addr_a = (state == ST_PASS) ? cnt : top_q;
    rd_addr_b = cnt - coin_q;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = (cnt == '0) ? COUNT_W'(1) : '0;
    end else begin
      wr_en   = s1_valid;
      wr_addr = s1_addr;
      wr_data = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      target_amount <= '0;
      out_valid     <= 1'b0;
      s1_valid      <= 1'b0;
      cnt           <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      s1_valid <= (state == ST_PASS);
      if (cfg_valid && cfg_ready) begin
        target_amount <= cfg_data;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_q     <= top_cfg;
      coin_q    <= coin_value[AW-1:0];
      coin_ok_q <= coin_ok_in;
      last_q    <= last_coin;
    end
    s1_addr  <= cnt;
    fwd_hit  <= s1_valid && (rd_addr_b == s1_addr);
    fwd_data <= sum;
    if (state == ST_EMIT && out_free) begin
      way_count <= rd_data_a;
    end
  end

  ccw_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_ways_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

`ifndef ASSERT_OFF
  a_s1_from_pass: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(state) == ST_PASS)
    else $error("table write-back without a preceding walk cycle");

  a_clear_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> cnt <= top_q)
    else $error("restart sweep ran past the target");

  a_pass_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_PASS |-> (cnt >= coin_q) && (cnt <= top_q))
    else $error("walk position outside coin..target");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result appeared without a read of the target entry");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state != ST_IDLE)
    else $error("table written while idle");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ccw_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccw_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ccw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// ===== verif/ccw_way_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccw_way_checker
// Watches the configuration, coin and count channels of the way counter. It
// keeps its own ways table, predicts each count and compares it in order.
// ----------------------------------------------------------------------------
module ccw_way_checker #(
  parameter int unsigned MAX_AMOUNT = 1023
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [ccw_pkg::TARGET_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [ccw_pkg::COIN_W-1:0]    coin_value,
  input  wire logic                          first_coin,
  input  wire logic                          last_coin,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [ccw_pkg::COUNT_W-1:0]   way_count,
  output int unsigned                        mismatch_count,
  output int unsigned                        counts_pending
);

  logic [ccw_pkg::COUNT_W-1:0]  ways_model [0:MAX_AMOUNT];
  logic [ccw_pkg::COUNT_W-1:0]  expected_counts [$];
  logic [ccw_pkg::COUNT_W-1:0]  oldest_count;
  logic [ccw_pkg::TARGET_W-1:0] target_model;

  initial begin
    mismatch_count = 0;
    counts_pending = 0;
    target_model   = '0;
    for (int i = 0; i <= MAX_AMOUNT; i++) begin
      ways_model[i] = '0;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ccw_way_checker: %s", $realtime, what);
    mismatch_count++;
  endtask

  // One coin transaction: optional restart, then the ascending table walk.
  task automatic apply_coin_to_ways(input logic [ccw_pkg::COIN_W-1:0] coin,
                                    input logic first, input logic last);
    int unsigned top;
    int unsigned t;
    top = target_model;
    if (top > MAX_AMOUNT) begin
      top = MAX_AMOUNT;
    end
    if (first) begin
      ways_model[0] = 1;
      for (t = 1; t <= top; t++) begin
        ways_model[t] = '0;
      end
    end
    if (coin != 0 && coin <= top) begin
      for (t = coin; t <= top; t++) begin
        ways_model[t] = ways_model[t] + ways_model[t - coin];
      end
    end
    if (last) begin
      expected_counts.push_back(ways_model[top]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_counts.delete();
      target_model = '0;
    end else begin
      // A count leaving now always belongs to an earlier coin, so it is
      // checked before this cycle's coin is applied.
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("way_count %h with no count pending", way_count));
        end else begin
          oldest_count = expected_counts.pop_front();
          if (way_count !== oldest_count) begin
            report_mismatch($sformatf("way_count got %h expected %h",
                                      way_count, oldest_count));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        target_model = cfg_data;
      end
      if (in_valid && !in_stall) begin
        apply_coin_to_ways(coin_value, first_coin, last_coin);
      end
    end
    counts_pending = expected_counts.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives coin sets and target settings into the way counter with random
// gaps and stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_AMOUNT  = 1023;
  localparam int unsigned TOTAL_ITEMS = 580;
  localparam int unsigned HOLD_CYCLES = 800;
  localparam longint     LIMIT_NS     = 8_000_000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ccw_pkg::TARGET_W-1:0] cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [ccw_pkg::COIN_W-1:0]   coin_value = '0;
  logic                         first_coin = 1'b0;
  logic                         last_coin = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ccw_pkg::COUNT_W-1:0]  way_count;

  int unsigned mismatch_count;
  int unsigned counts_pending;

  int unsigned items_sent  = 0;
  int unsigned target_now  = 0;
  int unsigned restart_max = 0;
  bit          restarted   = 1'b0;
  bit          tx_quiet    = 1'b0;
  logic        hold_go     = 1'b0;

  coin_change_way_counter_unit #(
    .MAX_AMOUNT(MAX_AMOUNT)
  ) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .coin_value(coin_value), .first_coin(first_coin), .last_coin(last_coin),
    .out_valid(out_valid), .out_stall(out_stall), .way_count(way_count)
  );

  ccw_way_checker #(
    .MAX_AMOUNT(MAX_AMOUNT)
  ) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .coin_value(coin_value), .first_coin(first_coin), .last_coin(last_coin),
    .out_valid(out_valid), .out_stall(out_stall), .way_count(way_count),
    .mismatch_count(mismatch_count), .counts_pending(counts_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: done, errors");
    $finish;
  end

  // Count receiver: a random stall before each transaction, occasional runs
  // with no stall, and one long hold-off that lets the block back up.
  logic out_took = 1'b0;
  int   hold_left = 0;
  int   rx_gap = 0;
  int   rx_quiet_left = 0;
  bit   hold_begun = 1'b0;

  always @(posedge clk) begin
    out_took <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (hold_go && !hold_begun) begin
      hold_begun = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (out_took) begin
      if (rx_quiet_left > 0) begin
        rx_gap = 0;
        rx_quiet_left--;
      end else begin
        rx_gap = $urandom_range(0, 14);
        if ($urandom_range(0, 24) == 0) begin
          rx_quiet_left = 20;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one coin and returns at the edge that accepts it.
  task automatic send_coin(input logic [ccw_pkg::COIN_W-1:0] coin,
                           input logic first, input logic last);
    int   gap;
    logic f;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    f   = first;
    // Without a restart the walk may only touch entries already written.
    if (!f && (!restarted || target_now > restart_max)) begin
      f = 1'b1;
    end
    if (f) begin
      restarted = 1'b1;
      if (target_now > restart_max) begin
        restart_max = target_now;
      end
    end
    if (coin != 0 || f || last) begin
      items_sent++;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    coin_value <= coin;
    first_coin <= f;
    last_coin  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every count has left and the last coin's walk has surely ended.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (counts_pending != 0) @(negedge clk);
    repeat (2 * target_now + 16) @(negedge clk);
  endtask

  task automatic write_target(input int unsigned amount);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= amount[ccw_pkg::TARGET_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    target_now = amount;
  endtask

  initial begin
    int unsigned phase;
    int unsigned tgt;
    int unsigned span;
    int unsigned phase_end;
    int unsigned set_len;
    int unsigned set_kind;
    int unsigned r;
    logic [ccw_pkg::COIN_W-1:0] coin;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Target zero: every set counts the single empty combination.
    write_target(0);
    send_coin(1, 1'b1, 1'b1);
    send_coin(16'hFFFF, 1'b1, 1'b1);
    send_coin(0, 1'b1, 1'b1);

    // Small target, including one-coin sets, a zero coin and a coin above
    // the target that both continue the previous table.
    write_target(10);
    send_coin(1, 1'b1, 1'b0);
    send_coin(2, 1'b0, 1'b0);
    send_coin(5, 1'b0, 1'b1);
    send_coin(3, 1'b1, 1'b1);
    send_coin(10, 1'b1, 1'b1);
    send_coin(0, 1'b0, 1'b1);
    send_coin(11, 1'b0, 1'b1);

    // The target drops in the middle of a set.
    write_target(20);
    send_coin(1, 1'b1, 1'b0);
    send_coin(5, 1'b0, 1'b0);
    write_target(15);
    send_coin(10, 1'b0, 1'b1);

    // Largest target: coins 1 to 8 make the count wrap past 32 bits.
    write_target(MAX_AMOUNT);
    send_coin(1, 1'b1, 1'b0);
    send_coin(2, 1'b0, 1'b0);
    send_coin(3, 1'b0, 1'b0);
    send_coin(16'hFFFF, 1'b0, 1'b0);
    send_coin(0, 1'b0, 1'b0);
    send_coin(4, 1'b0, 1'b0);
    send_coin(5, 1'b0, 1'b0);
    send_coin(6, 1'b0, 1'b0);
    send_coin(7, 1'b0, 1'b0);
    send_coin(8, 1'b0, 1'b1);
    send_coin(9, 1'b0, 1'b1);
    send_coin(MAX_AMOUNT, 1'b1, 1'b1);
    send_coin(16'h8000, 1'b1, 1'b1);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase == 3) begin
        tgt  = $urandom_range(4, 12);
        span = 30;
      end else if (phase % 10 == 6) begin
        tgt  = $urandom_range(512, MAX_AMOUNT);
        span = $urandom_range(8, 14);
      end else begin
        case ($urandom_range(0, 7))
          0:       tgt = 0;
          1:       tgt = 1;
          default: tgt = $urandom_range(2, 60);
        endcase
        span = $urandom_range(15, 30);
      end
      write_target(tgt);
      tx_quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        hold_go <= 1'b1;
      end
      phase_end = items_sent + span;
      while (items_sent < phase_end) begin
        set_len  = (phase == 3) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        // Kind 0 leaves the set open, kind 1 continues without a restart.
        set_kind = (phase == 3) ? 2 : $urandom_range(0, 9);
        for (int i = 0; i < set_len; i++) begin
          r = $urandom_range(0, 19);
          if (r == 0) begin
            coin = '0;
          end else if (r <= 3) begin
            coin = ccw_pkg::COIN_W'($urandom);
          end else if (tgt > 64 && r <= 11) begin
            coin = ccw_pkg::COIN_W'($urandom_range(1, 16));
          end else begin
            coin = ccw_pkg::COIN_W'($urandom_range(1, tgt + 2));
          end
          send_coin(coin, (i == 0) && (set_kind != 1),
                    (i == set_len - 1) && (set_kind != 0));
        end
      end
      phase++;
    end

    settle();
    if (mismatch_count == 0 && counts_pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ccw_pkg.sv
hw/rtl/ccw_ram.sv
hw/rtl/coin_change_way_counter_unit.sv
verif/ccw_way_checker.sv
verif/tb.sv
